FILE: design/sacc_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the set-associative cache controller.
// No dependencies; used by the top level.
package sacc_pkg;

   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_FLUSH = 2'd2;

   localparam logic [1:0] POLICY_RANDOM = 2'd0;
   localparam logic [1:0] POLICY_LRU    = 2'd1;
   localparam logic [1:0] POLICY_FIFO   = 2'd2;

   localparam logic WMODE_WRITE_BACK    = 1'b0;
   localparam logic WMODE_WRITE_THROUGH = 1'b1;

   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_WMODE  = 1'b1;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] address;
      logic [63:0] write_value;
      logic [3:0]  size_bytes;
   } req_type;

   typedef struct packed {
      logic [63:0] read_value;
      logic        hit;
      logic        line_dirty;
      logic        bypassed;
      logic [5:0]  set_number;
      logic [5:0]  tag_value;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] writeback_total;
   } rsp_type;

endpackage

FILE: design/sacc_ram.sv
`timescale 1ns / 1ps
// Generic synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module sacc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: design/set_assoc_cache_controller.sv
`timescale 1ns / 1ps
// Set-associative cache controller top level: sequencer, tag/stamp/data RAMs, main memory.
// Depends on sacc_pkg and sacc_ram.
//
// After reset the block zeroes all of main memory with busy high; configuration writes are
// taken during that time. An item is taken when start is high and busy low, and its result
// appears on rsp_data for one cycle with rsp_strobe; the receiver cannot stall it. Every step
// goes through single-byte RAM ports with registered read data, so the cost is set by the byte
// loops: a hit scans the set's tags and then moves each byte, a fill copies the block from main
// memory, a dirty eviction first writes the block back, victim choice scans the set's stamps
// (one draw for random), a bypass read goes byte by byte, and a flush visits every entry and
// writes back each dirty block. SETS, BLOCK_BYTES and MEM_BYTES must be powers of two.
module set_assoc_cache_controller #(
   parameter int WAYS        = 4,
   parameter int SETS        = 64,
   parameter int BLOCK_BYTES = 16,
   parameter int MEM_BYTES   = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sacc_pkg::req_type req,
   output logic              rsp_strobe,
   output sacc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [1:0]        csr_wdata
);
   import sacc_pkg::*;

   localparam int N     = WAYS * SETS;
   localparam int AW    = $clog2(MEM_BYTES);
   localparam int OFF_W = $clog2(BLOCK_BYTES);
   localparam int SL    = $clog2(SETS);
   localparam int SET_W = (SL > 0) ? SL : 1;
   localparam int TAG_W = AW - OFF_W - SL;
   localparam int ENT_W = (N > 1) ? $clog2(N) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int BW    = ENT_W + OFF_W;
   localparam int CW    = AW + 1;
   localparam int RND_K = 21;
   localparam logic [21:0] RND_M = 22'((2 ** RND_K + WAYS - 1) / WAYS);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_BYP, S_BYP_CAP, S_LOOK_RD, S_LOOK_CMP, S_MEMW, S_VICTIM,
      S_RAND, S_ST_RD, S_ST_CMP, S_EVICT, S_WB_TAG, S_WB_TAGW, S_WB_RD, S_WB_WR,
      S_FILL_RD, S_FILL_WR, S_FILL_DONE, S_ACC, S_ACC_RD, S_ACC_CAP, S_ACC_WR,
      S_FL, S_FL_NEXT, S_RESP
   } state_type;

   state_type         state_ff;
   logic [1:0]        func_ff;
   logic [AW-1:0]     a_ff;
   logic [63:0]       wv_ff;
   logic [3:0]        size_ff;
   logic [CW-1:0]     cnt_ff;
   logic [WAY_W-1:0]  way_ff;
   logic [WAY_W-1:0]  best_ff;
   logic [31:0]       best_stamp_ff;
   logic [ENT_W-1:0]  ent_ff;
   logic [SET_W-1:0]  fl_set_ff;
   logic [TAG_W-1:0]  wbtag_ff;
   logic [63:0]       rv_ff;
   logic              hit_ff, ldirty_ff, byp_ff;
   logic [31:0]       hit_cnt_ff, miss_cnt_ff, wb_cnt_ff, stamp_cnt_ff;
   logic [15:0]       lfsr_ff;
   logic [1:0]        policy_ff;
   logic              wmode_ff;
   logic [N-1:0]      valid_ff, dirty_ff, stwr_ff;
   logic              strobe_ff;
   rsp_type           rsp_ff;

   // RAM ports
   logic              m_we;
   logic [AW-1:0]     m_waddr, m_raddr;
   logic [7:0]        m_wdata, m_rdata;
   logic              b_we;
   logic [BW-1:0]     b_waddr, b_raddr;
   logic [7:0]        b_wdata, b_rdata;
   logic              t_we;
   logic [ENT_W-1:0]  t_raddr;
   logic [TAG_W-1:0]  t_rdata;
   logic              s_we;
   logic [ENT_W-1:0]  s_waddr;
   logic [31:0]       s_rdata;

   // Address decode and helpers
   logic [SET_W-1:0]  cur_set;
   logic [TAG_W-1:0]  cur_tag;
   logic [OFF_W-1:0]  cur_off;
   logic [ENT_W-1:0]  cur_ent;
   logic [ENT_W-1:0]  set_base;
   logic [2:0]        bi;
   logic [AW-1:0]     a_plus;
   logic [AW-1:0]     fill_addr;
   logic [SET_W-1:0]  wb_set;
   logic [AW-1:0]     wb_addr;
   logic [OFF_W-1:0]  acc_off;
   logic [3:0]        req_size;
   logic [AW-1:0]     req_a;
   logic [7:0]        req_end;
   logic              inv_found;
   logic [WAY_W-1:0]  inv_way;
   logic [37:0]       rnd_prod;
   logic [15:0]       rnd_q;
   logic [20:0]       rnd_qw;
   logic [WAY_W-1:0]  rnd_way;
   logic [31:0]       st_val;
   logic [WAY_W-1:0]  st_pick;
   logic              st_take;
   logic              lfsr_bit;
   logic [15:0]       lfsr_in;
   logic [31:0]       set32, tag32;

   assign cur_set   = SET_W'((a_ff >> OFF_W) & AW'(SETS - 1));
   assign cur_tag   = TAG_W'(a_ff >> (OFF_W + SL));
   assign cur_off   = a_ff[OFF_W-1:0];
   assign set_base  = ENT_W'(32'(cur_set) * WAYS);
   assign cur_ent   = ENT_W'(32'(set_base) + 32'(way_ff));
   assign bi        = cnt_ff[2:0];
   assign a_plus    = AW'(a_ff + AW'(cnt_ff));
   assign fill_addr = AW'({a_ff[AW-1:OFF_W], cnt_ff[OFF_W-1:0]});
   // a flush walks every set, an eviction stays in the set of the address
   assign wb_set    = (func_ff == FUNC_FLUSH) ? fl_set_ff : cur_set;
   assign wb_addr   = AW'((AW'(wbtag_ff) << (OFF_W + SL)) | (AW'(wb_set) << OFF_W)
                          | AW'(cnt_ff[OFF_W-1:0]));
   assign acc_off   = OFF_W'(cur_off + OFF_W'(cnt_ff));
   assign req_size  = (req.size_bytes > 4'd8) ? 4'd8 : req.size_bytes;
   assign req_a     = AW'(req.address);
   assign req_end   = 8'(req_a[OFF_W-1:0]) + 8'(req_size);
   assign lfsr_bit  = lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5];
   assign lfsr_in   = {lfsr_bit, lfsr_ff[15:1]};
   assign set32     = 32'(cur_set);
   assign tag32     = 32'(cur_tag);

   always_comb begin
      inv_found = 1'b0;
      inv_way   = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!valid_ff[ENT_W'(32'(set_base) + w)]) begin
            inv_found = 1'b1;
            inv_way   = WAY_W'(w);
         end
      end
   end

   // lfsr mod WAYS by reciprocal multiply, exact for 16-bit operands
   assign rnd_prod = 38'(lfsr_ff) * 38'(RND_M);
   assign rnd_q    = rnd_prod[RND_K +: 16];
   assign rnd_qw   = 21'(rnd_q) * 21'(WAYS);
   assign rnd_way  = WAY_W'(21'(lfsr_ff) - rnd_qw);

   assign st_val  = stwr_ff[cur_ent] ? s_rdata : 32'd0;
   assign st_take = (way_ff == '0) || (st_val < best_stamp_ff);
   assign st_pick = st_take ? way_ff : best_ff;

   // Memory port steering
   always_comb begin
      m_we    = 1'b0;
      m_waddr = a_plus;
      m_wdata = wv_ff[8*bi +: 8];
      m_raddr = a_plus;
      b_we    = 1'b0;
      b_waddr = {ent_ff, acc_off};
      b_wdata = wv_ff[8*bi +: 8];
      b_raddr = {ent_ff, acc_off};
      t_we    = 1'b0;
      t_raddr = cur_ent;
      s_we    = 1'b0;
      s_waddr = ent_ff;
      case (state_ff)
         S_CLEAR: begin
            m_we    = 1'b1;
            m_waddr = cnt_ff[AW-1:0];
            m_wdata = 8'd0;
         end
         S_BYP:     m_we = (func_ff == FUNC_WRITE);
         S_MEMW:    m_we = 1'b1;
         S_WB_TAG:  t_raddr = ent_ff;
         S_WB_RD:   b_raddr = {ent_ff, cnt_ff[OFF_W-1:0]};
         S_WB_WR: begin
            m_we    = 1'b1;
            m_waddr = wb_addr;
            m_wdata = b_rdata;
         end
         S_FILL_RD: m_raddr = fill_addr;
         S_FILL_WR: begin
            b_we    = 1'b1;
            b_waddr = {ent_ff, cnt_ff[OFF_W-1:0]};
            b_wdata = m_rdata;
         end
         S_FILL_DONE: begin
            t_we = 1'b1;
            s_we = (policy_ff == POLICY_FIFO);
         end
         S_ACC:     s_we = (policy_ff == POLICY_LRU);
         S_ACC_WR: begin
            b_we = 1'b1;
            m_we = (wmode_ff == WMODE_WRITE_THROUGH);
         end
         default: ;
      endcase
   end

   sacc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main (
      .clock(clock), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
      .raddr(m_raddr), .rdata(m_rdata)
   );
   sacc_ram #(.WIDTH(8), .DEPTH(N * BLOCK_BYTES)) u_data (
      .clock(clock), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
      .raddr(b_raddr), .rdata(b_rdata)
   );
   sacc_ram #(.WIDTH(TAG_W), .DEPTH(N)) u_tag (
      .clock(clock), .we(t_we), .waddr(ent_ff), .wdata(cur_tag),
      .raddr(t_raddr), .rdata(t_rdata)
   );
   sacc_ram #(.WIDTH(32), .DEPTH(N)) u_stamp (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(stamp_cnt_ff),
      .raddr(cur_ent), .rdata(s_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         wb_cnt_ff    <= '0;
         stamp_cnt_ff <= '0;
         lfsr_ff      <= 16'h0001;
         policy_ff    <= POLICY_LRU;
         wmode_ff     <= WMODE_WRITE_BACK;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         stwr_ff      <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         if (csr_we) begin
            if (csr_index == CSR_POLICY) begin
               policy_ff <= csr_wdata;
            end else begin
               wmode_ff <= csr_wdata[0];
            end
         end
         if (s_we) begin
            stwr_ff[ent_ff] <= 1'b1;
            stamp_cnt_ff    <= stamp_cnt_ff + 32'd1;
         end
         case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(MEM_BYTES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  func_ff   <= req.func;
                  a_ff      <= req_a;
                  wv_ff     <= req.write_value;
                  size_ff   <= req_size;
                  cnt_ff    <= '0;
                  way_ff    <= '0;
                  ent_ff    <= '0;
                  fl_set_ff <= '0;
                  rv_ff     <= '0;
                  hit_ff    <= 1'b0;
                  ldirty_ff <= 1'b0;
                  byp_ff    <= 1'b0;
                  if (req.func == FUNC_FLUSH) begin
                     state_ff <= S_FL;
                  end else if (req.func != FUNC_READ && req.func != FUNC_WRITE) begin
                     state_ff <= S_RESP;
                  end else if (req_end > 8'(BLOCK_BYTES)) begin
                     byp_ff   <= 1'b1;
                     state_ff <= S_BYP;
                  end else begin
                     state_ff <= S_LOOK_RD;
                  end
               end
            end
            S_BYP: begin
               if (func_ff == FUNC_WRITE) begin
                  cnt_ff <= cnt_ff + CW'(1);
                  if (cnt_ff + CW'(1) == CW'(size_ff)) begin
                     state_ff <= S_RESP;
                  end
               end else begin
                  state_ff <= S_BYP_CAP;
               end
            end
            S_BYP_CAP: begin
               rv_ff[8*bi +: 8] <= m_rdata;
               cnt_ff           <= cnt_ff + CW'(1);
               state_ff         <= (cnt_ff + CW'(1) == CW'(size_ff)) ? S_RESP : S_BYP;
            end
            S_LOOK_RD: state_ff <= S_LOOK_CMP;
            S_LOOK_CMP: begin
               if (valid_ff[cur_ent] && t_rdata == cur_tag) begin
                  hit_ff <= 1'b1;
                  ent_ff <= cur_ent;
                  if (hit_cnt_ff != '1) hit_cnt_ff <= hit_cnt_ff + 32'd1;
                  state_ff <= S_ACC;
               end else if (way_ff == WAY_W'(WAYS - 1)) begin
                  if (miss_cnt_ff != '1) miss_cnt_ff <= miss_cnt_ff + 32'd1;
                  if (func_ff == FUNC_WRITE && wmode_ff == WMODE_WRITE_THROUGH) begin
                     if (wb_cnt_ff != '1) wb_cnt_ff <= wb_cnt_ff + 32'd1;
                     state_ff <= (size_ff == 4'd0) ? S_RESP : S_MEMW;
                  end else begin
                     state_ff <= S_VICTIM;
                  end
               end else begin
                  way_ff   <= way_ff + WAY_W'(1);
                  state_ff <= S_LOOK_RD;
               end
            end
            S_MEMW: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff + CW'(1) == CW'(size_ff)) begin
                  state_ff <= S_RESP;
               end
            end
            S_VICTIM: begin
               way_ff <= '0;
               cnt_ff <= '0;
               if (inv_found) begin
                  ent_ff   <= ENT_W'(32'(set_base) + 32'(inv_way));
                  state_ff <= S_EVICT;
               end else if (policy_ff == POLICY_RANDOM) begin
                  lfsr_ff  <= lfsr_in;
                  state_ff <= S_RAND;
               end else if (policy_ff == POLICY_LRU || policy_ff == POLICY_FIFO) begin
                  state_ff <= S_ST_RD;
               end else begin
                  ent_ff   <= set_base;
                  state_ff <= S_EVICT;
               end
            end
            S_RAND: begin
               ent_ff   <= ENT_W'(32'(set_base) + 32'(rnd_way));
               state_ff <= S_EVICT;
            end
            S_ST_RD: state_ff <= S_ST_CMP;
            S_ST_CMP: begin
               if (st_take) begin
                  best_ff       <= way_ff;
                  best_stamp_ff <= st_val;
               end
               if (way_ff == WAY_W'(WAYS - 1)) begin
                  ent_ff   <= ENT_W'(32'(set_base) + 32'(st_pick));
                  state_ff <= S_EVICT;
               end else begin
                  way_ff   <= way_ff + WAY_W'(1);
                  state_ff <= S_ST_RD;
               end
            end
            S_EVICT: begin
               cnt_ff <= '0;
               if (dirty_ff[ent_ff]) begin
                  if (wb_cnt_ff != '1) wb_cnt_ff <= wb_cnt_ff + 32'd1;
                  state_ff <= S_WB_TAG;
               end else begin
                  state_ff <= S_FILL_RD;
               end
            end
            S_WB_TAG:  state_ff <= S_WB_TAGW;
            S_WB_TAGW: begin
               wbtag_ff <= t_rdata;
               state_ff <= S_WB_RD;
            end
            S_WB_RD: state_ff <= S_WB_WR;
            S_WB_WR: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(BLOCK_BYTES - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= (func_ff == FUNC_FLUSH) ? S_FL_NEXT : S_FILL_RD;
               end else begin
                  state_ff <= S_WB_RD;
               end
            end
            S_FILL_RD: state_ff <= S_FILL_WR;
            S_FILL_WR: begin
               cnt_ff <= cnt_ff + CW'(1);
               state_ff <= (cnt_ff == CW'(BLOCK_BYTES - 1)) ? S_FILL_DONE : S_FILL_RD;
            end
            S_FILL_DONE: begin
               valid_ff[ent_ff] <= 1'b1;
               dirty_ff[ent_ff] <= 1'b0;
               state_ff         <= S_ACC;
            end
            S_ACC: begin
               ldirty_ff <= dirty_ff[ent_ff];
               cnt_ff    <= '0;
               if (func_ff == FUNC_WRITE) begin
                  if (wmode_ff == WMODE_WRITE_THROUGH) begin
                     if (wb_cnt_ff != '1) wb_cnt_ff <= wb_cnt_ff + 32'd1;
                  end else begin
                     dirty_ff[ent_ff] <= 1'b1;
                  end
               end
               if (size_ff == 4'd0) begin
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= (func_ff == FUNC_WRITE) ? S_ACC_WR : S_ACC_RD;
               end
            end
            S_ACC_RD: state_ff <= S_ACC_CAP;
            S_ACC_CAP: begin
               rv_ff[8*bi +: 8] <= b_rdata;
               cnt_ff           <= cnt_ff + CW'(1);
               state_ff <= (cnt_ff + CW'(1) == CW'(size_ff)) ? S_RESP : S_ACC_RD;
            end
            S_ACC_WR: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff + CW'(1) == CW'(size_ff)) begin
                  state_ff <= S_RESP;
               end
            end
            S_FL: begin
               cnt_ff <= '0;
               if (valid_ff[ent_ff] && dirty_ff[ent_ff]) begin
                  if (wb_cnt_ff != '1) wb_cnt_ff <= wb_cnt_ff + 32'd1;
                  state_ff <= S_WB_TAG;
               end else begin
                  state_ff <= S_FL_NEXT;
               end
            end
            S_FL_NEXT: begin
               // drop the entry, then advance
               valid_ff[ent_ff] <= 1'b0;
               dirty_ff[ent_ff] <= 1'b0;
               if (ent_ff == ENT_W'(N - 1)) begin
                  state_ff <= S_RESP;
               end else begin
                  ent_ff <= ent_ff + ENT_W'(1);
                  if (way_ff == WAY_W'(WAYS - 1)) begin
                     way_ff    <= '0;
                     fl_set_ff <= fl_set_ff + SET_W'(1);
                  end else begin
                     way_ff <= way_ff + WAY_W'(1);
                  end
                  state_ff <= S_FL;
               end
            end
            S_RESP: begin
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Result beat register; payload needs no reset
   always_ff @(posedge clock) begin
      if (state_ff == S_RESP) begin
         rsp_ff.read_value      <= rv_ff;
         rsp_ff.hit             <= hit_ff;
         rsp_ff.line_dirty      <= ldirty_ff;
         rsp_ff.bypassed        <= byp_ff;
         rsp_ff.set_number      <= set32[5:0];
         rsp_ff.tag_value       <= tag32[5:0];
         rsp_ff.hit_total       <= hit_cnt_ff;
         rsp_ff.miss_total      <= miss_cnt_ff;
         rsp_ff.writeback_total <= wb_cnt_ff;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_hit_not_bypass: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.hit && rsp_data.bypassed))
      else $error("bypassed access reported as hit");

   a_hits_monotone: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> hit_cnt_ff >= $past(hit_cnt_ff))
      else $error("hit counter went backwards");

   a_stamp_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(s_we)) |-> $stable(stamp_cnt_ff))
      else $error("stamp counter moved without a stamp write");
`endif
endmodule
